### hdl/brbrc_pkg.sv
// ----------------------------------------------------------------------------
// brbrc_pkg: shared types and constants
// Codes, default sizes and the result record of the byte ring buffer.
// ----------------------------------------------------------------------------
package brbrc_pkg;

  localparam int STORE_DEPTH_DEF = 1024;
  localparam int MAX_BURST_DEF   = 64;

  // Result queue between the sequencer and the output port.
  localparam int OBUF_DEPTH = 4;
  localparam int OBUF_LW    = $clog2(OBUF_DEPTH + 1);

  // Item kinds.
  localparam logic [2:0] KIND_CLEAR   = 3'd0;
  localparam logic [2:0] KIND_RESERVE = 3'd1;
  localparam logic [2:0] KIND_PUT     = 3'd2;
  localparam logic [2:0] KIND_COMMIT  = 3'd3;
  localparam logic [2:0] KIND_ABORT   = 3'd4;
  localparam logic [2:0] KIND_READ    = 3'd5;
  localparam logic [2:0] KIND_PEEK    = 3'd6;
  localparam logic [2:0] KIND_SEARCH  = 3'd7;

  // Result status codes.
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_REFUSED   = 2'd1;
  localparam logic [1:0] ST_NOT_FOUND = 2'd2;
  localparam logic [1:0] ST_EMPTY     = 2'd3;

  typedef struct packed {
    logic [1:0]  status;
    logic [7:0]  data;
    logic        valid;
    logic [9:0]  offset;
    logic [10:0] amount;
    logic [10:0] fill;
    logic        last;
  } res_t;

endpackage

### hdl/brbrc_ram.sv
// ----------------------------------------------------------------------------
// brbrc_ram: byte store
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module brbrc_ram #(
  parameter int DEPTH = brbrc_pkg::STORE_DEPTH_DEF,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [7:0]    wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [7:0]    rdata
);

  logic [7:0] mem [DEPTH];
  logic [7:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

### hdl/brbrc_obuf.sv
// ----------------------------------------------------------------------------
// brbrc_obuf: result queue
// Small FIFO of result records feeding the output stream port.
// ----------------------------------------------------------------------------
module brbrc_obuf (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                push,
  input  brbrc_pkg::res_t                     push_data,
  output logic [brbrc_pkg::OBUF_LW-1:0]       level,
  output logic                                out_valid,
  input  logic                                out_ready,
  output brbrc_pkg::res_t                     out_data
);

  localparam int PW = $clog2(brbrc_pkg::OBUF_DEPTH);

  brbrc_pkg::res_t                  entry_r [brbrc_pkg::OBUF_DEPTH];
  logic [PW-1:0]                    wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]                    rd_ptr_r, rd_ptr_nxt;
  logic [brbrc_pkg::OBUF_LW-1:0]    level_r, level_nxt;
  logic                             pop;

  assign pop       = out_valid && out_ready;
  assign out_valid = (level_r != '0);
  assign out_data  = entry_r[rd_ptr_r];
  assign level     = level_r;

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + PW'(1) : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + PW'(1) : rd_ptr_r;
    level_nxt  = level_r;
    if (push && !pop) begin
      level_nxt = level_r + brbrc_pkg::OBUF_LW'(1);
    end else if (pop && !push) begin
      level_nxt = level_r - brbrc_pkg::OBUF_LW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      level_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      level_r  <= level_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

### hdl/brbrc_ctl.sv
// ----------------------------------------------------------------------------
// brbrc_ctl: ring control and walk sequencer
// Holds head, fill, reservation and capacity; runs store walks for
// read, peek and search.
// ----------------------------------------------------------------------------
module brbrc_ctl #(
  parameter int STORE_DEPTH = brbrc_pkg::STORE_DEPTH_DEF,
  parameter int MAX_BURST   = brbrc_pkg::MAX_BURST_DEF,
  parameter int AW          = $clog2(STORE_DEPTH)
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_valid,
  input  logic [10:0]                   cfg_data,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [2:0]                    in_kind,
  input  logic [7:0]                    in_byte,
  input  logic [10:0]                   in_count,
  output logic                          mem_we,
  output logic [AW-1:0]                 mem_waddr,
  output logic [7:0]                    mem_wdata,
  output logic                          mem_re,
  output logic [AW-1:0]                 mem_raddr,
  input  logic [7:0]                    mem_rdata,
  input  logic [brbrc_pkg::OBUF_LW-1:0] ob_level,
  output logic                          push,
  output brbrc_pkg::res_t               push_data
);

  localparam int LW = (AW + 1 > 11) ? AW + 1 : 11;
  localparam logic [LW-1:0] DEPTH_L = LW'(STORE_DEPTH);
  localparam logic [LW-1:0] BURST_L = LW'(MAX_BURST);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_WALK = 1'b1;

  logic          state_r, state_nxt;
  logic [AW-1:0] head_r, head_nxt;
  logic [LW-1:0] held_r, held_nxt;
  logic          open_r, open_nxt;
  logic [LW-1:0] resv_r, resv_nxt;
  logic [LW-1:0] staged_r, staged_nxt;
  logic [AW-1:0] put_ptr_r, put_ptr_nxt;
  logic [LW-1:0] cap_r, cap_nxt;
  logic [AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [LW-1:0] left_r, left_nxt;
  logic          pend_r, pend_nxt;
  logic [LW-1:0] pend_idx_r, pend_idx_nxt;
  logic [LW-1:0] next_idx_r, next_idx_nxt;
  logic [LW-1:0] last_idx_r, last_idx_nxt;
  logic          srch_r, srch_nxt;
  logic [7:0]    key_r, key_nxt;
  logic [LW-1:0] amt_r, amt_nxt;

  logic          accept;
  logic [LW-1:0] cnt_l;
  logic [LW-1:0] cfg_l;
  logic [LW:0]   tail_sum;
  logic [LW:0]   tail_w;
  logic [LW-1:0] put_inc;
  logic [LW-1:0] rd_inc;
  logic [LW-1:0] n_rd;
  logic [LW:0]   head_sum;
  logic [LW:0]   head_w;
  logic [LW-1:0] n_cm;
  logic          hit;
  logic          room;
  logic          issue;

  assign in_ready = (state_r == S_IDLE) && (ob_level < brbrc_pkg::OBUF_LW'(brbrc_pkg::OBUF_DEPTH));
  assign accept   = in_valid && in_ready;
  assign cnt_l    = LW'(in_count);
  assign cfg_l    = LW'(cfg_data);

  // Wrapped pointer arithmetic; every sum stays below twice the capacity.
  assign tail_sum = {1'b0, LW'(head_r)} + {1'b0, held_r};
  assign tail_w   = (tail_sum >= {1'b0, cap_r}) ? tail_sum - {1'b0, cap_r} : tail_sum;
  assign put_inc  = LW'(put_ptr_r) + LW'(1);
  assign rd_inc   = LW'(rd_ptr_r) + LW'(1);
  assign n_cm     = (cnt_l < resv_r) ? cnt_l : resv_r;

  always_comb begin
    n_rd = (cnt_l < held_r) ? cnt_l : held_r;
    if (n_rd > BURST_L) begin
      n_rd = BURST_L;
    end
  end

  assign head_sum = {1'b0, LW'(head_r)} + {1'b0, n_rd};
  assign head_w   = (head_sum >= {1'b0, cap_r}) ? head_sum - {1'b0, cap_r} : head_sum;

  assign hit   = pend_r && srch_r && (mem_rdata == key_r);
  // The read issued now lands next cycle; keep a slot for it and for any
  // beat landing this cycle.
  assign room  = ({1'b0, ob_level} + (brbrc_pkg::OBUF_LW + 1)'(pend_r))
                 < (brbrc_pkg::OBUF_LW + 1)'(brbrc_pkg::OBUF_DEPTH);
  assign issue = (state_r == S_WALK) && (left_r != '0) && !hit && room;

  always_comb begin
    state_nxt    = state_r;
    head_nxt     = head_r;
    held_nxt     = held_r;
    open_nxt     = open_r;
    resv_nxt     = resv_r;
    staged_nxt   = staged_r;
    put_ptr_nxt  = put_ptr_r;
    cap_nxt      = cap_r;
    rd_ptr_nxt   = rd_ptr_r;
    left_nxt     = left_r;
    pend_nxt     = 1'b0;
    pend_idx_nxt = pend_idx_r;
    next_idx_nxt = next_idx_r;
    last_idx_nxt = last_idx_r;
    srch_nxt     = srch_r;
    key_nxt      = key_r;
    amt_nxt      = amt_r;

    mem_we    = 1'b0;
    mem_waddr = put_ptr_r;
    mem_wdata = in_byte;
    mem_re    = 1'b0;
    mem_raddr = rd_ptr_r;

    push      = 1'b0;
    push_data = '0;
    push_data.last = 1'b1;
    push_data.status = brbrc_pkg::ST_OK;

    if (cfg_valid) begin
      // Capacity write: clamp into range, empty the ring.
      if (cfg_l == '0) begin
        cap_nxt = LW'(1);
      end else if (cfg_l > DEPTH_L) begin
        cap_nxt = DEPTH_L;
      end else begin
        cap_nxt = cfg_l;
      end
      head_nxt   = '0;
      held_nxt   = '0;
      open_nxt   = 1'b0;
      resv_nxt   = '0;
      staged_nxt = '0;
    end else if (accept) begin
      push = 1'b1;
      case (in_kind)
        brbrc_pkg::KIND_CLEAR: begin
          head_nxt   = '0;
          held_nxt   = '0;
          open_nxt   = 1'b0;
          resv_nxt   = '0;
          staged_nxt = '0;
        end
        brbrc_pkg::KIND_RESERVE: begin
          if (open_r || ((cap_r - held_r) < cnt_l)) begin
            push_data.status = brbrc_pkg::ST_REFUSED;
          end else begin
            open_nxt    = 1'b1;
            resv_nxt    = cnt_l;
            staged_nxt  = '0;
            put_ptr_nxt = tail_w[AW-1:0];
            push_data.amount = cnt_l[10:0];
          end
        end
        brbrc_pkg::KIND_PUT: begin
          if (!open_r || (staged_r >= resv_r)) begin
            push_data.status = brbrc_pkg::ST_REFUSED;
          end else begin
            mem_we      = 1'b1;
            staged_nxt  = staged_r + LW'(1);
            put_ptr_nxt = (put_inc == cap_r) ? '0 : put_inc[AW-1:0];
            push_data.amount = 11'd1;
          end
        end
        brbrc_pkg::KIND_COMMIT: begin
          if (!open_r) begin
            push_data.status = brbrc_pkg::ST_REFUSED;
          end else begin
            held_nxt   = held_r + n_cm;
            open_nxt   = 1'b0;
            resv_nxt   = '0;
            staged_nxt = '0;
            push_data.amount = n_cm[10:0];
          end
        end
        brbrc_pkg::KIND_ABORT: begin
          if (!open_r) begin
            push_data.status = brbrc_pkg::ST_REFUSED;
          end else begin
            open_nxt   = 1'b0;
            resv_nxt   = '0;
            staged_nxt = '0;
          end
        end
        brbrc_pkg::KIND_READ, brbrc_pkg::KIND_PEEK: begin
          if (held_r == '0) begin
            push_data.status = brbrc_pkg::ST_EMPTY;
          end else begin
            if (in_kind == brbrc_pkg::KIND_READ) begin
              head_nxt = head_w[AW-1:0];
              held_nxt = held_r - n_rd;
            end
            if (n_rd != '0) begin
              // Bytes follow from the walk; hold the beat until then.
              push         = 1'b0;
              state_nxt    = S_WALK;
              rd_ptr_nxt   = head_r;
              left_nxt     = n_rd;
              next_idx_nxt = '0;
              last_idx_nxt = n_rd - LW'(1);
              srch_nxt     = 1'b0;
              amt_nxt      = n_rd;
            end
          end
        end
        default: begin
          // Search.
          if (held_r == '0) begin
            push_data.status = brbrc_pkg::ST_NOT_FOUND;
          end else begin
            push         = 1'b0;
            state_nxt    = S_WALK;
            rd_ptr_nxt   = head_r;
            left_nxt     = held_r;
            next_idx_nxt = '0;
            last_idx_nxt = held_r - LW'(1);
            srch_nxt     = 1'b1;
            key_nxt      = in_byte;
            amt_nxt      = '0;
          end
        end
      endcase
      push_data.fill = held_nxt[10:0];
    end else if (state_r == S_WALK) begin
      push_data.fill = held_r[10:0];
      if (pend_r) begin
        if (!srch_r) begin
          push             = 1'b1;
          push_data.data   = mem_rdata;
          push_data.valid  = 1'b1;
          push_data.amount = amt_r[10:0];
          push_data.last   = (pend_idx_r == last_idx_r);
          if (pend_idx_r == last_idx_r) begin
            state_nxt = S_IDLE;
          end
        end else if (hit) begin
          push             = 1'b1;
          push_data.offset = pend_idx_r[9:0];
          state_nxt        = S_IDLE;
        end else if (pend_idx_r == last_idx_r) begin
          push             = 1'b1;
          push_data.status = brbrc_pkg::ST_NOT_FOUND;
          state_nxt        = S_IDLE;
        end
      end
      if (issue) begin
        mem_re       = 1'b1;
        rd_ptr_nxt   = (rd_inc == cap_r) ? '0 : rd_inc[AW-1:0];
        left_nxt     = left_r - LW'(1);
        pend_nxt     = 1'b1;
        pend_idx_nxt = next_idx_r;
        next_idx_nxt = next_idx_r + LW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      head_r     <= '0;
      held_r     <= '0;
      open_r     <= 1'b0;
      resv_r     <= '0;
      staged_r   <= '0;
      put_ptr_r  <= '0;
      cap_r      <= DEPTH_L;
      left_r     <= '0;
      pend_r     <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      head_r     <= head_nxt;
      held_r     <= held_nxt;
      open_r     <= open_nxt;
      resv_r     <= resv_nxt;
      staged_r   <= staged_nxt;
      put_ptr_r  <= put_ptr_nxt;
      cap_r      <= cap_nxt;
      left_r     <= left_nxt;
      pend_r     <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rd_ptr_r   <= rd_ptr_nxt;
    pend_idx_r <= pend_idx_nxt;
    next_idx_r <= next_idx_nxt;
    last_idx_r <= last_idx_nxt;
    srch_r     <= srch_nxt;
    key_r      <= key_nxt;
    amt_r      <= amt_nxt;
  end

endmodule

### hdl/byte_ring_buffer_reserve_commit_top.sv
// ----------------------------------------------------------------------------
// byte_ring_buffer_reserve_commit_top: byte ring buffer with reserve/commit
// Circular byte store with reservation-based writes, burst reads and search.
// ----------------------------------------------------------------------------
// Usage:
//   Items enter on the in_ stream (kind in in_tuser, byte and count in
//   in_tdata); results leave on the out_ stream, tlast marking the final
//   beat of an item. The cfg_ channel writes the capacity (wrap point);
//   write it only while the block is idle. A capacity write empties the
//   ring and drops any open reservation.
//   Timing: one item is worked at a time. Clear, reserve, put, commit,
//   abort and the single-beat cases of read, peek and search finish at the
//   edge that takes them, so puts stream at one byte per clock while the
//   result queue has room. Reads, peeks and searches walk the store through
//   its single read port at one byte per cycle while the queue has room.
//   A single-beat result is queued at the edge that takes the item; a walk
//   beat passes the store's read data register and then the result queue,
//   and no new item is taken until the walk's last beat is queued.
//   Reset (rst_n low, synchronous) empties the ring, closes the reservation
//   and sets the capacity to the full store. Store contents are not cleared.
//   A stalled receiver fills a four-beat result queue; the walk then pauses
//   and in_tready drops until room returns. No beat is lost.
// ----------------------------------------------------------------------------
module byte_ring_buffer_reserve_commit_top #(
  parameter int STORE_DEPTH = brbrc_pkg::STORE_DEPTH_DEF,
  parameter int MAX_BURST   = brbrc_pkg::MAX_BURST_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  // Configuration: capacity write.
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [10:0] cfg_data,     // capacity
  // Item stream.
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,     // [7:0] data_byte, [18:8] count, [23:19] zero
  input  logic [2:0]  in_tuser,     // [2:0] kind
  // Result stream.
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,    // [7:0] out_byte, [17:8] found_offset,
                                    // [28:18] amount, [39:29] fill_level
  output logic [2:0]  out_tuser,    // [1:0] status, [2] byte_valid
  output logic        out_tlast     // last
);

  localparam int AW = $clog2(STORE_DEPTH);

  logic                          mem_we;
  logic [AW-1:0]                 mem_waddr;
  logic [7:0]                    mem_wdata;
  logic                          mem_re;
  logic [AW-1:0]                 mem_raddr;
  logic [7:0]                    mem_rdata;
  logic [brbrc_pkg::OBUF_LW-1:0] ob_level;
  logic                          push;
  brbrc_pkg::res_t               push_data;
  brbrc_pkg::res_t               out_res;

  // Capacity writes go straight into the capacity register; always take them.
  assign cfg_ready = 1'b1;

  // Ring control: owns head, fill, reservation and capacity, and walks the
  // store for read, peek and search.
  brbrc_ctl #(
    .STORE_DEPTH (STORE_DEPTH),
    .MAX_BURST   (MAX_BURST),
    .AW          (AW)
  ) u_ctl (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_data  (cfg_data),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_kind   (in_tuser),
    .in_byte   (in_tdata[7:0]),
    .in_count  (in_tdata[18:8]),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_re    (mem_re),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata),
    .ob_level  (ob_level),
    .push      (push),
    .push_data (push_data)
  );

  // Byte store: puts write it; walks read one byte per cycle unless paused.
  brbrc_ram #(
    .DEPTH (STORE_DEPTH),
    .AW    (AW)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // Result queue: decouples the receiver's stalls from the sequencer.
  brbrc_obuf u_obuf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .level     (ob_level),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_data  (out_res)
  );

  // Pack the result beat.
  assign out_tdata = {out_res.fill, out_res.amount, out_res.offset, out_res.data};
  assign out_tuser = {out_res.valid, out_res.status};
  assign out_tlast = out_res.last;

endmodule

### tb/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for byte_ring_buffer_reserve_commit_top
// Drives items on the in_ stream and capacity writes on the cfg_ channel.
// A behavioral ring model predicts every result beat. A checker compares
// each beat leaving the out_ stream against the oldest prediction. Both
// streams see random gaps and stalls.
// ----------------------------------------------------------------------------
module testbench;
  import brbrc_pkg::*;

  logic        clk;
  logic        rst_n;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [10:0] cfg_data;      // capacity
  logic        in_tvalid;
  logic        in_tready;
  logic [23:0] in_tdata;      // [7:0] data_byte, [18:8] count, [23:19] zero
  logic [2:0]  in_tuser;      // [2:0] kind
  logic        out_tvalid;
  logic        out_tready;
  logic [39:0] out_tdata;     // [7:0] out_byte, [17:8] found_offset,
                              // [28:18] amount, [39:29] fill_level
  logic [2:0]  out_tuser;     // [1:0] status, [2] byte_valid
  logic        out_tlast;

  byte_ring_buffer_reserve_commit_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  // 10 ns clock.
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // --------------------------------------------------------------------------
  // Ring model: physical byte store, head, fill and the open reservation.
  // ring_written marks store entries that have seen a put, so that stimulus
  // never commits (and later reads) an entry holding no defined byte.
  // --------------------------------------------------------------------------
  logic [7:0] ring_mem     [0:STORE_DEPTH_DEF-1];
  bit         ring_written [0:STORE_DEPTH_DEF-1];
  int         ring_cap;
  int         ring_head;
  int         ring_held;
  bit         rsv_open;
  int         rsv_size;
  int         rsv_staged;

  res_t pending_beats [$];   // predicted result beats, oldest first
  int   mismatches;
  int   beats_seen;
  int   items_sent;
  bit   steady;              // when set, neither side idles

  function automatic int ring_pos(int base, int offs);
    return (base + offs) % ring_cap;
  endfunction

  function automatic void empty_ring();
    ring_head  = 0;
    ring_held  = 0;
    rsv_open   = 1'b0;
    rsv_size   = 0;
    rsv_staged = 0;
  endfunction

  function automatic void push_beat(logic [1:0] st, logic [7:0] b, logic v,
                                    int offs, int amt, logic lst);
    res_t r;
    r.status = st;
    r.data   = b;
    r.valid  = v;
    r.offset = 10'(offs);
    r.amount = 11'(amt);
    r.fill   = 11'(ring_held);
    r.last   = lst;
    pending_beats.push_back(r);
  endfunction

  // Update the model for one accepted item and queue the beats it causes.
  function automatic void predict_item(logic [2:0] kind, logic [7:0] dbyte,
                                       logic [10:0] cnt);
    int n;
    int start;
    int c;
    c = int'(cnt);
    case (kind)
      KIND_CLEAR: begin
        empty_ring();
        push_beat(ST_OK, 8'h00, 1'b0, 0, 0, 1'b1);
      end
      KIND_RESERVE: begin
        if (rsv_open || ring_cap - ring_held < c) begin
          push_beat(ST_REFUSED, 8'h00, 1'b0, 0, 0, 1'b1);
        end else begin
          rsv_open   = 1'b1;
          rsv_size   = c;
          rsv_staged = 0;
          push_beat(ST_OK, 8'h00, 1'b0, 0, c, 1'b1);
        end
      end
      KIND_PUT: begin
        if (!rsv_open || rsv_staged >= rsv_size) begin
          push_beat(ST_REFUSED, 8'h00, 1'b0, 0, 0, 1'b1);
        end else begin
          start = ring_pos(ring_head, ring_held + rsv_staged);
          ring_mem[start]     = dbyte;
          ring_written[start] = 1'b1;
          rsv_staged++;
          push_beat(ST_OK, 8'h00, 1'b0, 0, 1, 1'b1);
        end
      end
      KIND_COMMIT: begin
        if (!rsv_open) begin
          push_beat(ST_REFUSED, 8'h00, 1'b0, 0, 0, 1'b1);
        end else begin
          n = (c < rsv_size) ? c : rsv_size;
          ring_held += n;
          rsv_open   = 1'b0;
          rsv_size   = 0;
          rsv_staged = 0;
          push_beat(ST_OK, 8'h00, 1'b0, 0, n, 1'b1);
        end
      end
      KIND_ABORT: begin
        if (!rsv_open) begin
          push_beat(ST_REFUSED, 8'h00, 1'b0, 0, 0, 1'b1);
        end else begin
          rsv_open   = 1'b0;
          rsv_size   = 0;
          rsv_staged = 0;
          push_beat(ST_OK, 8'h00, 1'b0, 0, 0, 1'b1);
        end
      end
      KIND_READ, KIND_PEEK: begin
        start = ring_head;
        if (ring_held == 0) begin
          push_beat(ST_EMPTY, 8'h00, 1'b0, 0, 0, 1'b1);
        end else begin
          n = (c < ring_held) ? c : ring_held;
          if (n > MAX_BURST_DEF) n = MAX_BURST_DEF;
          // Fill level on every beat is the level after the whole burst.
          if (kind == KIND_READ) begin
            ring_head  = ring_pos(ring_head, n);
            ring_held -= n;
          end
          if (n == 0) begin
            push_beat(ST_OK, 8'h00, 1'b0, 0, 0, 1'b1);
          end else begin
            for (int i = 0; i < n; i++)
              push_beat(ST_OK, ring_mem[ring_pos(start, i)], 1'b1, 0, n, i == n - 1);
          end
        end
      end
      default: begin
        n = -1;
        for (int i = 0; i < ring_held; i++)
          if (n < 0 && ring_mem[ring_pos(ring_head, i)] == dbyte) n = i;
        if (n >= 0) push_beat(ST_OK, 8'h00, 1'b0, n, 0, 1'b1);
        else        push_beat(ST_NOT_FOUND, 8'h00, 1'b0, 0, 0, 1'b1);
      end
    endcase
  endfunction

  // Shrink a commit count so that every committed entry holds a put byte.
  function automatic logic [10:0] safe_commit(logic [10:0] cnt);
    int n;
    int good;
    n    = (int'(cnt) < rsv_size) ? int'(cnt) : rsv_size;
    good = 0;
    while (good < n && ring_written[ring_pos(ring_head, ring_held + good)]) good++;
    return (good < n) ? 11'(good) : cnt;
  endfunction

  // Mostly back to back, some short gaps, a few long ones.
  function automatic int pick_gap();
    int r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 40);
  endfunction

  // --------------------------------------------------------------------------
  // Driving side. Inputs change at the falling edge; a beat is taken at the
  // rising edge where valid and ready are both high.
  // --------------------------------------------------------------------------
  task automatic send_item(input logic [2:0] kind, input logic [7:0] dbyte,
                           input logic [10:0] cnt);
    int gap;
    gap = pick_gap();
    @(negedge clk);
    if (gap > 0) begin
      in_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tuser  = kind;
    in_tdata  = {5'b0, cnt, dbyte};
    do @(posedge clk); while (!in_tready);
    predict_item(kind, dbyte, cnt);
    items_sent++;
  endtask

  // Drop valid and hold until every predicted beat has left the block.
  task automatic wait_drained();
    @(negedge clk);
    in_tvalid = 1'b0;
    while (pending_beats.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // Write the capacity with the block idle; the ring empties.
  task automatic write_capacity(input logic [10:0] value);
    int eff;
    wait_drained();
    cfg_valid = 1'b1;
    cfg_data  = value;
    do @(posedge clk); while (!cfg_ready);
    if (value == 11'd0)                     eff = 1;
    else if (int'(value) > STORE_DEPTH_DEF) eff = STORE_DEPTH_DEF;
    else                                    eff = int'(value);
    ring_cap = eff;
    empty_ring();
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // Receiver: alternate runs of ready with stalls of random length.
  initial begin
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      out_tready = 1'b1;
      repeat ($urandom_range(0, 11)) @(negedge clk);
      if (pick_gap() > 0) begin
        @(negedge clk);
        out_tready = 1'b0;
        repeat (pick_gap()) @(negedge clk);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Checking side.
  // --------------------------------------------------------------------------
  task automatic report_mismatch(input string msg);
    mismatches++;
    $display("mismatch at %0t ns: %s", $time, msg);
  endtask

  task automatic check_field(input string name, input int got, input int want);
    if (got != want)
      report_mismatch($sformatf("beat %0d %s: got %0d, want %0d",
                                beats_seen, name, got, want));
  endtask

  always @(posedge clk) begin : check_beats
    res_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_beats.size() == 0) begin
        report_mismatch($sformatf("beat %0d arrived with nothing expected", beats_seen));
      end else begin
        want = pending_beats.pop_front();
        check_field("status",       out_tuser[1:0],   want.status);
        check_field("out_byte",     out_tdata[7:0],   want.data);
        check_field("byte_valid",   out_tuser[2],     want.valid);
        check_field("found_offset", out_tdata[17:8],  want.offset);
        check_field("amount",       out_tdata[28:18], want.amount);
        check_field("fill_level",   out_tdata[39:29], want.fill);
        check_field("last",         out_tlast,        want.last);
      end
      beats_seen++;
    end
  end

  // --------------------------------------------------------------------------
  // Directed tests.
  // --------------------------------------------------------------------------

  // Every operation but reserve on a freshly reset, empty ring.
  task automatic test_empty_store();
    send_item(KIND_READ,   8'h00, 11'd5);    // empty
    send_item(KIND_PEEK,   8'hFF, 11'd1);    // empty
    send_item(KIND_SEARCH, 8'h00, 11'd0);    // not found on empty store
    send_item(KIND_PUT,    8'hFF, 11'd0);    // no reservation
    send_item(KIND_COMMIT, 8'h00, 11'd3);    // no reservation
    send_item(KIND_ABORT,  8'h00, 11'd0);    // no reservation
    send_item(KIND_CLEAR,  8'h00, 11'd0);
  endtask

  // Reservation lifecycle, commit saturation, burst clamps and search.
  task automatic test_reserve_commit();
    send_item(KIND_RESERVE, 8'h00, 11'd0);     // empty reservation opens
    send_item(KIND_RESERVE, 8'h00, 11'd1);     // refused while open
    send_item(KIND_PUT,     8'h12, 11'd0);     // past reserved size
    send_item(KIND_COMMIT,  8'h00, 11'd0);
    send_item(KIND_RESERVE, 8'h00, 11'd1025);  // more than the capacity
    send_item(KIND_RESERVE, 8'h00, 11'd4);
    send_item(KIND_PUT,     8'h00, 11'd0);
    send_item(KIND_PUT,     8'hFF, 11'd2047);
    send_item(KIND_PUT,     8'hA5, 11'd0);
    send_item(KIND_PUT,     8'h5A, 11'd0);
    send_item(KIND_PUT,     8'h33, 11'd0);     // one past the reservation
    send_item(KIND_COMMIT,  8'h00, 11'd2047);  // saturate at 4
    send_item(KIND_PEEK,    8'h00, 11'd0);     // zero bytes from non-empty
    send_item(KIND_PEEK,    8'h00, 11'd3);
    send_item(KIND_SEARCH,  8'h5A, 11'd0);
    send_item(KIND_SEARCH,  8'h11, 11'd0);     // no match
    send_item(KIND_READ,    8'h00, 11'd2);
    send_item(KIND_READ,    8'h00, 11'd2047);  // clamp to held bytes
  endtask

  // Abort, partial commit, and clear with an open reservation.
  task automatic test_abort_and_clear();
    send_item(KIND_RESERVE, 8'h00, 11'd3);
    send_item(KIND_PUT,     8'h01, 11'd0);
    send_item(KIND_ABORT,   8'h00, 11'd0);
    send_item(KIND_RESERVE, 8'h00, 11'd2);
    send_item(KIND_PUT,     8'h7E, 11'd0);
    send_item(KIND_COMMIT,  8'h00, 11'd1);
    send_item(KIND_RESERVE, 8'h00, 11'd1);
    send_item(KIND_PUT,     8'h81, 11'd0);
    send_item(KIND_CLEAR,   8'h00, 11'd0);     // drops bytes and reservation
    send_item(KIND_PUT,     8'h42, 11'd0);     // refused after clear
  endtask

  // Small capacity with wrap, unstaged commit, and out-of-range capacities.
  task automatic test_capacity_limits();
    write_capacity(11'd4);
    send_item(KIND_RESERVE, 8'h00, 11'd4);
    for (int i = 0; i < 4; i++) send_item(KIND_PUT, 8'(8'h10 + i), 11'd0);
    send_item(KIND_COMMIT,  8'h00, 11'd4);
    send_item(KIND_RESERVE, 8'h00, 11'd1);     // full
    send_item(KIND_READ,    8'h00, 11'd3);
    send_item(KIND_RESERVE, 8'h00, 11'd3);
    for (int i = 0; i < 3; i++) send_item(KIND_PUT, 8'(8'h20 + i), 11'd0);
    send_item(KIND_COMMIT,  8'h00, 11'd3);
    send_item(KIND_SEARCH,  8'h22, 11'd0);
    send_item(KIND_READ,    8'h00, 11'd64);    // crosses the wrap point
    // Commit more than was staged: entries keep their earlier bytes.
    send_item(KIND_RESERVE, 8'h00, 11'd4);
    send_item(KIND_PUT,     8'hC3, 11'd0);
    send_item(KIND_COMMIT,  8'h00, safe_commit(11'd4));
    send_item(KIND_PEEK,    8'h00, 11'd4);

    write_capacity(11'd0);                     // acts as one byte
    send_item(KIND_RESERVE, 8'h00, 11'd2);
    send_item(KIND_RESERVE, 8'h00, 11'd1);
    send_item(KIND_PUT,     8'hEE, 11'd0);
    send_item(KIND_COMMIT,  8'h00, 11'd1);
    send_item(KIND_READ,    8'h00, 11'd1);

    write_capacity(11'd2047);                  // acts as the full store
    send_item(KIND_RESERVE, 8'h00, 11'd1024);
    send_item(KIND_ABORT,   8'h00, 11'd0);
  endtask

  // --------------------------------------------------------------------------
  // Random traffic: mostly complete reserve/put/commit transactions and
  // reads, with searches, noise items and an occasional clear.
  // --------------------------------------------------------------------------
  task automatic random_write_txn();
    int room;
    int k;
    int j;
    int r;
    logic [10:0] c;
    if (rsv_open) send_item(KIND_ABORT, 8'($urandom), 11'd0);
    room = ring_cap - ring_held;
    r = $urandom_range(0, 99);
    if (r < 70)      k = $urandom_range(0, (room < 24) ? room : 24);
    else if (r < 85) k = (room < 64) ? room : 64;
    else             k = room + 1;             // refused: no room
    send_item(KIND_RESERVE, 8'($urandom), 11'(k));
    if (!rsv_open) return;
    r = $urandom_range(0, 99);
    if (r < 85)      j = k;
    else if (r < 95) j = $urandom_range(0, k);
    else             j = k + 1;                // one put too many
    repeat (j) send_item(KIND_PUT, 8'($urandom), 11'($urandom_range(0, 2047)));
    r = $urandom_range(0, 99);
    if (r < 20) begin
      send_item(KIND_ABORT, 8'($urandom), 11'($urandom_range(0, 2047)));
    end else begin
      if (r < 60)      c = 11'(j);
      else if (r < 80) c = 11'd2047;
      else             c = 11'($urandom_range(0, k));
      send_item(KIND_COMMIT, 8'($urandom), safe_commit(c));
    end
  endtask

  task automatic random_read();
    int r;
    logic [10:0] c;
    r = $urandom_range(0, 99);
    if (r < 40)      c = 11'($urandom_range(1, 8));
    else if (r < 65) c = 11'($urandom_range(0, ring_held));
    else if (r < 80) c = 11'(MAX_BURST_DEF);
    else if (r < 90) c = 11'd2047;
    else             c = 11'd0;
    send_item($urandom_range(0, 1) ? KIND_READ : KIND_PEEK, 8'($urandom), c);
  endtask

  task automatic random_search();
    logic [7:0] b;
    if (ring_held > 0 && $urandom_range(0, 99) < 60)
      b = ring_mem[ring_pos(ring_head, $urandom_range(0, ring_held - 1))];
    else
      b = 8'($urandom);
    send_item(KIND_SEARCH, b, 11'($urandom_range(0, 2047)));
  endtask

  task automatic random_noise();
    logic [2:0]  k;
    logic [10:0] c;
    k = 3'($urandom_range(0, 7));
    c = 11'($urandom_range(0, 2047));
    if (k == KIND_COMMIT) c = safe_commit(c);
    send_item(k, 8'($urandom), c);
  endtask

  task automatic run_random(input int target);
    int first;
    int r;
    first = items_sent;
    while (items_sent - first < target) begin
      r = $urandom_range(0, 99);
      if (r < 40)      random_write_txn();
      else if (r < 70) random_read();
      else if (r < 80) random_search();
      else if (r < 95) random_noise();
      else             send_item(KIND_CLEAR, 8'($urandom), 11'($urandom_range(0, 2047)));
    end
  endtask

  task automatic test_random_traffic();
    write_capacity(11'd1024);
    run_random(8);
    write_capacity(11'($urandom_range(5, 64)));
    run_random(5);
    wait_drained();                            // sender holds off until drained
    run_random(4);
    write_capacity(11'd16);
    steady = 1'b1;                             // stretch with no idling
    run_random(4);
    steady = 1'b0;
    write_capacity(11'd1);
    run_random(4);
  endtask

  // --------------------------------------------------------------------------
  // Main sequence.
  // --------------------------------------------------------------------------
  initial begin
    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    in_tuser   = '0;
    cfg_valid  = 1'b0;
    cfg_data   = '0;
    mismatches = 0;
    beats_seen = 0;
    items_sent = 0;
    steady     = 1'b0;
    ring_cap   = STORE_DEPTH_DEF;
    empty_ring();
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_empty_store();
    test_reserve_commit();
    test_abort_and_clear();
    test_capacity_limits();
    test_random_traffic();

    wait_drained();
    repeat (10) @(posedge clk);
    if (mismatches == 0 && pending_beats.size() == 0)
      $display("[byte_ring_buffer_reserve_commit_top] OK");
    else
      $display("[byte_ring_buffer_reserve_commit_top] ERROR");
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #20ms;
    $display("[byte_ring_buffer_reserve_commit_top] ERROR");
    $finish;
  end

endmodule

### byte_ring_buffer_reserve_commit_top.f
hdl/brbrc_pkg.sv
hdl/brbrc_ram.sv
hdl/brbrc_obuf.sv
hdl/brbrc_ctl.sv
hdl/byte_ring_buffer_reserve_commit_top.sv
tb/testbench.sv
